// ===== sv/trt_pkg.sv =====
package trt_pkg;

    // Number formats
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 24;
    localparam int DIR_W     = 18;
    localparam int CFG_W     = 23;

    // Configuration port
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    // Internal datapath widths, sized from the ranges of the operands.
    localparam int W_W       = COORD_W + 1;          // oB - oA
    localparam int N_W       = 21;                   // dA x dB after the floor shift
    localparam int NN_W      = 40;                   // n . n
    localparam int C_W       = 23;                   // dB x n, dA x n after the floor shift
    localparam int NUM_W     = C_W + W_W;            // c . w
    localparam int Q_W       = 40;                   // quotient bits below the saturation point
    localparam int T_W       = Q_W + 1;              // signed ray parameter
    localparam int T_SPLIT   = 24;                   // low part of t for the split multiply

    // Pipeline organization
    localparam int DIV_BPS   = 2;                    // quotient bits resolved per stage
    localparam int DIV_STEPS = Q_W / DIV_BPS;
    localparam int FRONT_ST  = 6;
    localparam int DIV_ST    = DIV_STEPS + 1;
    localparam int PT_ST     = 8;
    localparam int PIPE_ST   = FRONT_ST + DIV_ST + PT_ST;

    // Rotating component indexes for the cross products.
    localparam int NXT1 [3] = '{1, 2, 0};
    localparam int NXT2 [3] = '{2, 0, 1};

    typedef enum logic [1:0] {
        REG_GAP   = 2'd0,
        REG_RANGE = 2'd1,
        REG_DEPTH = 2'd2
    } cfg_idx_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIR_W-1:0]   dir_t;
    typedef logic signed [NUM_W-1:0]   num_t;

    typedef struct packed {
        coord_t [2:0] oa;
        coord_t [2:0] ob;
        dir_t   [2:0] da;
        dir_t   [2:0] db;
        logic         par;
    } side_t;

    typedef struct packed {
        num_t [1:0]        num;
        logic [NN_W-1:0]   nn;
    } front_res_t;

    typedef struct packed {
        logic [1:0][Q_W-1:0] quo;
        logic [1:0]          neg;
        logic [1:0]          sat;
    } div_res_t;

    typedef struct packed {
        logic [CFG_W-1:0] gap;
        logic [CFG_W-1:0] rng;
        logic [CFG_W-1:0] depth;
    } cfg_t;

endpackage

// ===== sv/trt_front.sv =====
// Cross products, n . n and the two numerators, six register stages.
module trt_front (
    input  logic                          clk,
    input  logic [trt_pkg::FRONT_ST-1:0]  en,
    input  trt_pkg::side_t                side_in,
    output trt_pkg::side_t                side_out,
    output trt_pkg::front_res_t           res
);

    localparam int FB   = trt_pkg::FRAC_BITS;
    localparam int DW   = trt_pkg::DIR_W;
    localparam int NW   = trt_pkg::N_W;
    localparam int CW   = trt_pkg::C_W;
    localparam int WW   = trt_pkg::W_W;
    localparam int NNW  = trt_pkg::NN_W;
    localparam int NUMW = trt_pkg::NUM_W;
    localparam int PW1  = 2 * DW;
    localparam int DW1  = PW1 + 1;
    localparam int PW2  = DW + NW;
    localparam int DW2  = PW2 + 1;
    localparam int SQF  = 2 * NW;
    localparam int EW   = CW + WW;

    logic signed [PW1-1:0]  p1_reg [3];
    logic signed [PW1-1:0]  p2_reg [3];
    logic signed [NW-1:0]   n_reg [3];
    logic signed [PW2-1:0]  qb1_reg [3];
    logic signed [PW2-1:0]  qb2_reg [3];
    logic signed [PW2-1:0]  qa1_reg [3];
    logic signed [PW2-1:0]  qa2_reg [3];
    logic [NNW-1:0]         sq_reg [3];
    logic signed [CW-1:0]   cb_reg [3];
    logic signed [CW-1:0]   ca_reg [3];
    logic [NNW-1:0]         nn3_reg;
    logic [NNW-1:0]         nn4_reg;
    logic signed [EW-1:0]   eb_reg [3];
    logic signed [EW-1:0]   ea_reg [3];
    logic signed [WW-1:0]   w_reg [4][3];
    trt_pkg::side_t         side_reg [trt_pkg::FRONT_ST];
    trt_pkg::front_res_t    res_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            side_reg[0] <= side_in;
            for (int i = 0; i < 3; i++)
            begin
                p1_reg[i]   <= PW1'($signed(side_in.da[trt_pkg::NXT1[i]]))
                             * PW1'($signed(side_in.db[trt_pkg::NXT2[i]]));
                p2_reg[i]   <= PW1'($signed(side_in.da[trt_pkg::NXT2[i]]))
                             * PW1'($signed(side_in.db[trt_pkg::NXT1[i]]));
                w_reg[0][i] <= WW'($signed(side_in.ob[i])) - WW'($signed(side_in.oa[i]));
            end
        end

        if (en[1])
        begin
            side_reg[1] <= side_reg[0];
            for (int i = 0; i < 3; i++)
            begin
                n_reg[i]    <= NW'((DW1'(p1_reg[i]) - DW1'(p2_reg[i])) >>> FB);
                w_reg[1][i] <= w_reg[0][i];
            end
        end

        if (en[2])
        begin
            side_reg[2] <= side_reg[1];
            for (int i = 0; i < 3; i++)
            begin
                qb1_reg[i]  <= PW2'($signed(side_reg[1].db[trt_pkg::NXT1[i]]))
                             * PW2'(n_reg[trt_pkg::NXT2[i]]);
                qb2_reg[i]  <= PW2'($signed(side_reg[1].db[trt_pkg::NXT2[i]]))
                             * PW2'(n_reg[trt_pkg::NXT1[i]]);
                qa1_reg[i]  <= PW2'($signed(side_reg[1].da[trt_pkg::NXT1[i]]))
                             * PW2'(n_reg[trt_pkg::NXT2[i]]);
                qa2_reg[i]  <= PW2'($signed(side_reg[1].da[trt_pkg::NXT2[i]]))
                             * PW2'(n_reg[trt_pkg::NXT1[i]]);
                sq_reg[i]   <= NNW'(SQF'(n_reg[i]) * SQF'(n_reg[i]));
                w_reg[2][i] <= w_reg[1][i];
            end
        end

        if (en[3])
        begin
            side_reg[3] <= side_reg[2];
            nn3_reg     <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            for (int i = 0; i < 3; i++)
            begin
                cb_reg[i]   <= CW'((DW2'(qb1_reg[i]) - DW2'(qb2_reg[i])) >>> FB);
                ca_reg[i]   <= CW'((DW2'(qa1_reg[i]) - DW2'(qa2_reg[i])) >>> FB);
                w_reg[3][i] <= w_reg[2][i];
            end
        end

        if (en[4])
        begin
            side_reg[4] <= side_reg[3];
            nn4_reg     <= nn3_reg;
            for (int i = 0; i < 3; i++)
            begin
                eb_reg[i] <= EW'(cb_reg[i]) * EW'(w_reg[3][i]);
                ea_reg[i] <= EW'(ca_reg[i]) * EW'(w_reg[3][i]);
            end
        end

        if (en[5])
        begin
            side_reg[5].oa  <= side_reg[4].oa;
            side_reg[5].ob  <= side_reg[4].ob;
            side_reg[5].da  <= side_reg[4].da;
            side_reg[5].db  <= side_reg[4].db;
            side_reg[5].par <= (nn4_reg == '0);
            res_reg.nn      <= nn4_reg;
            res_reg.num[0]  <= NUMW'(eb_reg[0]) + NUMW'(eb_reg[1]) + NUMW'(eb_reg[2]);
            res_reg.num[1]  <= NUMW'(ea_reg[0]) + NUMW'(ea_reg[1]) + NUMW'(ea_reg[2]);
        end
    end

    assign side_out = side_reg[trt_pkg::FRONT_ST-1];
    assign res      = res_reg;

endmodule

// ===== sv/trt_div.sv =====
// Pipelined restoring divider: two quotients over one divisor, two quotient bits per stage.
module trt_div (
    input  logic                        clk,
    input  logic [trt_pkg::DIV_ST-1:0]  en,
    input  trt_pkg::side_t              side_in,
    input  trt_pkg::front_res_t         fin,
    output trt_pkg::side_t              side_out,
    output trt_pkg::div_res_t           dout
);

    localparam int FB   = trt_pkg::FRAC_BITS;
    localparam int QW   = trt_pkg::Q_W;
    localparam int NUMW = trt_pkg::NUM_W;
    localparam int NNW  = trt_pkg::NN_W;
    localparam int DVW  = NUMW + FB;
    localparam int ST   = trt_pkg::DIV_ST;
    localparam int BPS  = trt_pkg::DIV_BPS;

    logic [QW-1:0]   rem_reg [ST][2];
    logic [QW-1:0]   dvd_reg [ST][2];
    logic [QW-1:0]   quo_reg [ST][2];
    logic [1:0]      neg_reg [ST];
    logic [1:0]      sat_reg [ST];
    logic [NNW-1:0]  nn_reg [ST];
    trt_pkg::side_t  side_reg [ST];

    logic [QW-1:0]   rem_next [ST][2];
    logic [QW-1:0]   dvd_next [ST][2];
    logic [QW-1:0]   quo_next [ST][2];
    logic [1:0]      neg_next;
    logic [1:0]      sat_next;

    always_comb
    begin
        logic signed [NUMW-1:0] num;
        logic [NUMW-1:0]        mag;
        logic [DVW-1:0]         full;
        logic [QW:0]            acc;
        logic [QW-1:0]          r;
        logic [QW-1:0]          d;
        logic [QW-1:0]          q;

        // Entry stage: magnitude, sign, saturation test and initial remainder.
        for (int l = 0; l < 2; l++)
        begin
            num            = $signed(fin.num[l]);
            neg_next[l]    = num[NUMW-1];
            mag            = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
            full           = {mag, {FB{1'b0}}};
            rem_next[0][l] = QW'(full[DVW-1:QW]);
            dvd_next[0][l] = full[QW-1:0];
            quo_next[0][l] = '0;
            sat_next[l]    = (QW'(full[DVW-1:QW]) >= fin.nn);
        end

        // Each later stage resolves BPS quotient bits from the stage before it.
        for (int k = 1; k < ST; k++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                r = rem_reg[k-1][l];
                d = dvd_reg[k-1][l];
                q = quo_reg[k-1][l];
                for (int j = 0; j < BPS; j++)
                begin
                    acc = {r, d[QW-1]};
                    d   = {d[QW-2:0], 1'b0};
                    if (acc >= {1'b0, nn_reg[k-1]})
                    begin
                        acc = acc - {1'b0, nn_reg[k-1]};
                        q   = {q[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        q   = {q[QW-2:0], 1'b0};
                    end
                    r = acc[QW-1:0];
                end
                rem_next[k][l] = r;
                dvd_next[k][l] = d;
                quo_next[k][l] = q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            side_reg[0] <= side_in;
            nn_reg[0]   <= fin.nn;
            neg_reg[0]  <= neg_next;
            sat_reg[0]  <= sat_next;
            for (int l = 0; l < 2; l++)
            begin
                rem_reg[0][l] <= rem_next[0][l];
                dvd_reg[0][l] <= dvd_next[0][l];
                quo_reg[0][l] <= quo_next[0][l];
            end
        end
        for (int k = 1; k < ST; k++)
        begin
            if (en[k])
            begin
                side_reg[k] <= side_reg[k-1];
                nn_reg[k]   <= nn_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                sat_reg[k]  <= sat_reg[k-1];
                for (int l = 0; l < 2; l++)
                begin
                    rem_reg[k][l] <= rem_next[k][l];
                    dvd_reg[k][l] <= dvd_next[k][l];
                    quo_reg[k][l] <= quo_next[k][l];
                end
            end
        end
    end

    assign side_out    = side_reg[ST-1];
    assign dout.quo[0] = quo_reg[ST-1][0];
    assign dout.quo[1] = quo_reg[ST-1][1];
    assign dout.neg    = neg_reg[ST-1];
    assign dout.sat    = sat_reg[ST-1];

endmodule

// ===== sv/trt_point.sv =====
// Closest points, midpoint and the acceptance tests, eight register stages.
module trt_point (
    input  logic                       clk,
    input  logic [trt_pkg::PT_ST-1:0]  en,
    input  trt_pkg::side_t             side_in,
    input  trt_pkg::div_res_t          din,
    input  trt_pkg::cfg_t              cfg,
    output trt_pkg::coord_t            point_x,
    output trt_pkg::coord_t            point_y,
    output trt_pkg::coord_t            point_z,
    output logic                       point_ok
);

    localparam int FB   = trt_pkg::FRAC_BITS;
    localparam int CDW  = trt_pkg::COORD_W;
    localparam int DW   = trt_pkg::DIR_W;
    localparam int QW   = trt_pkg::Q_W;
    localparam int TW   = trt_pkg::T_W;
    localparam int TS   = trt_pkg::T_SPLIT;
    localparam int CFW  = trt_pkg::CFG_W;
    localparam int HW   = DW + TW - TS;
    localparam int LW   = DW + TS + 1;
    localparam int PRW  = DW + TW;
    localparam int PPW  = PRW - FB + 1;
    localparam int GW   = PPW + 1;
    localparam int SQW  = 2 * CFW;
    localparam int SMW  = SQW + 2;

    logic signed [TW-1:0]   t_reg [2];
    logic signed [HW-1:0]   hi_reg [2][3];
    logic signed [LW-1:0]   lo_reg [2][3];
    logic signed [PRW-1:0]  prod_reg [2][3];
    logic signed [PPW-1:0]  p_reg [2][3];
    logic signed [GW-1:0]   g_reg [3];
    logic signed [PPW-1:0]  m_reg [3][3];
    logic [CFW-1:0]         agl_reg [3];
    logic [CFW-1:0]         aml_reg [3];
    logic [SQW-1:0]         sqg_reg [3];
    logic [SQW-1:0]         sqm_reg [3];
    logic [SQW-1:0]         lim_g_reg;
    logic [SQW-1:0]         lim_m_reg;
    logic [1:0]             exg_reg;
    logic [1:0]             exm_reg;
    logic [1:0]             dep_reg;
    logic [2:0]             par_reg;
    trt_pkg::side_t         side_reg [4];
    trt_pkg::coord_t        pt_reg [3];
    logic                   ok_reg;

    logic [GW-1:0]          ag [3];
    logic [PPW-1:0]         am [3];
    logic                   exg;
    logic                   exm;
    logic [TW-1:0]          tmag [2];
    logic [SMW-1:0]         sum_g;
    logic [SMW-1:0]         sum_m;
    logic                   ok_next;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            tmag[l] = din.sat[l] ? TW'({QW{1'b1}}) : TW'(din.quo[l]);
        end
        exg = 1'b0;
        exm = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            ag[i] = g_reg[i][GW-1] ? GW'(-g_reg[i]) : GW'(g_reg[i]);
            am[i] = m_reg[0][i][PPW-1] ? PPW'(-m_reg[0][i]) : PPW'(m_reg[0][i]);
            exg   = exg | (ag[i] > GW'(cfg.gap));
            exm   = exm | (am[i] > PPW'(cfg.rng));
        end
        sum_g   = SMW'(sqg_reg[0]) + SMW'(sqg_reg[1]) + SMW'(sqg_reg[2]);
        sum_m   = SMW'(sqm_reg[0]) + SMW'(sqm_reg[1]) + SMW'(sqm_reg[2]);
        ok_next = !par_reg[2] && !exg_reg[1] && !exm_reg[1] && !dep_reg[1]
               && (sum_g <= SMW'(lim_g_reg)) && (sum_m <= SMW'(lim_m_reg));
    end

    always_ff @(posedge clk)
    begin
        // Signed ray parameters, saturated.
        if (en[0])
        begin
            side_reg[0] <= side_in;
            for (int l = 0; l < 2; l++)
            begin
                t_reg[l] <= din.neg[l] ? $signed(-tmag[l]) : $signed(tmag[l]);
            end
        end

        // d * t as two partial products.
        if (en[1])
        begin
            side_reg[1] <= side_reg[0];
            for (int i = 0; i < 3; i++)
            begin
                hi_reg[0][i] <= HW'($signed(side_reg[0].da[i]))
                              * HW'($signed(t_reg[0][TW-1:TS]));
                lo_reg[0][i] <= LW'($signed(side_reg[0].da[i]))
                              * LW'($signed({1'b0, t_reg[0][TS-1:0]}));
                hi_reg[1][i] <= HW'($signed(side_reg[0].db[i]))
                              * HW'($signed(t_reg[1][TW-1:TS]));
                lo_reg[1][i] <= LW'($signed(side_reg[0].db[i]))
                              * LW'($signed({1'b0, t_reg[1][TS-1:0]}));
            end
        end

        if (en[2])
        begin
            side_reg[2] <= side_reg[1];
            for (int l = 0; l < 2; l++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    prod_reg[l][i] <= (PRW'(hi_reg[l][i]) <<< TS) + PRW'(lo_reg[l][i]);
                end
            end
        end

        // Closest points.
        if (en[3])
        begin
            side_reg[3] <= side_reg[2];
            for (int i = 0; i < 3; i++)
            begin
                p_reg[0][i] <= PPW'($signed(side_reg[2].oa[i]))
                             + PPW'(prod_reg[0][i] >>> FB);
                p_reg[1][i] <= PPW'($signed(side_reg[2].ob[i]))
                             + PPW'(prod_reg[1][i] >>> FB);
            end
        end

        // Gap vector and midpoint.
        if (en[4])
        begin
            par_reg[0] <= side_reg[3].par;
            for (int i = 0; i < 3; i++)
            begin
                g_reg[i]    <= GW'(p_reg[0][i]) - GW'(p_reg[1][i]);
                m_reg[0][i] <= PPW'((GW'(p_reg[0][i]) + GW'(p_reg[1][i])) >>> 1);
            end
        end

        // Per-component bounds and the depth test.
        if (en[5])
        begin
            par_reg[1] <= par_reg[0];
            exg_reg[0] <= exg;
            exm_reg[0] <= exm;
            dep_reg[0] <= (m_reg[0][2] < PPW'($signed({1'b0, cfg.depth})));
            for (int i = 0; i < 3; i++)
            begin
                agl_reg[i]  <= ag[i][CFW-1:0];
                aml_reg[i]  <= am[i][CFW-1:0];
                m_reg[1][i] <= m_reg[0][i];
            end
        end

        // Squares for the norm tests.
        if (en[6])
        begin
            par_reg[2] <= par_reg[1];
            exg_reg[1] <= exg_reg[0];
            exm_reg[1] <= exm_reg[0];
            dep_reg[1] <= dep_reg[0];
            lim_g_reg  <= SQW'(cfg.gap) * SQW'(cfg.gap);
            lim_m_reg  <= SQW'(cfg.rng) * SQW'(cfg.rng);
            for (int i = 0; i < 3; i++)
            begin
                sqg_reg[i]  <= SQW'(agl_reg[i]) * SQW'(agl_reg[i]);
                sqm_reg[i]  <= SQW'(aml_reg[i]) * SQW'(aml_reg[i]);
                m_reg[2][i] <= m_reg[1][i];
            end
        end

        // Final decision and output register.
        if (en[7])
        begin
            ok_reg <= ok_next;
            for (int i = 0; i < 3; i++)
            begin
                pt_reg[i] <= ok_next ? $signed(m_reg[2][i][CDW-1:0]) : '0;
            end
        end
    end

    assign point_x  = pt_reg[0];
    assign point_y  = pt_reg[1];
    assign point_z  = pt_reg[2];
    assign point_ok = ok_reg;

endmodule

// ===== sv/two_ray_triangulation_core.sv =====
// Two-ray triangulation core.
//
// One ray pair transaction is offered on the ray channel (ray_valid, ray_stall) with the
// origins and directions of rays A and B. The core returns one result transaction on the
// res channel (res_valid, res_stall): the midpoint of the closest points of the two rays
// and point_valid. A rejected pair (parallel rays, gap above gap_threshold, midpoint beyond
// max_range or below min_depth) returns point_valid low and a zero point.
//
// The datapath is a 35-stage pipeline: 6 stages of cross and dot products, 21 stages of
// a restoring divider that resolves two quotient bits per stage, and 8 stages of closest
// point, midpoint and norm tests. One pair is taken in every cycle while ray_stall is low.
// Each stage holds a valid bit; a stage advances when it is empty or the stage after it
// advances, so bubbles collapse.
//
// When the receiver asserts res_stall, the final stage holds its result and the stages
// behind it keep filling; ray_stall rises only once every stage holds a transaction.
// Reset clears all valid bits and loads the threshold registers with their defaults (gap
// 1.0 m, range 20.0 m, depth 1.0 m). The user writes them over the APB port, at byte
// addresses 0, 4 and 8, only while no transaction is in flight; not enforced by the core.
module two_ray_triangulation_core (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        ray_valid,
    output logic                        ray_stall,
    input  logic signed [23:0]          origin_a_x,
    input  logic signed [23:0]          origin_a_y,
    input  logic signed [23:0]          origin_a_z,
    input  logic signed [17:0]          dir_a_x,
    input  logic signed [17:0]          dir_a_y,
    input  logic signed [17:0]          dir_a_z,
    input  logic signed [23:0]          origin_b_x,
    input  logic signed [23:0]          origin_b_y,
    input  logic signed [23:0]          origin_b_z,
    input  logic signed [17:0]          dir_b_x,
    input  logic signed [17:0]          dir_b_y,
    input  logic signed [17:0]          dir_b_z,

    output logic                        res_valid,
    input  logic                        res_stall,
    output logic signed [23:0]          point_x,
    output logic signed [23:0]          point_y,
    output logic signed [23:0]          point_z,
    output logic                        point_valid,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [trt_pkg::ADDR_W-1:0]  paddr,
    input  logic [trt_pkg::DATA_W-1:0]  pwdata,
    output logic [trt_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int S   = trt_pkg::PIPE_ST;
    localparam int FS  = trt_pkg::FRONT_ST;
    localparam int DS  = trt_pkg::DIV_ST;
    localparam int PS  = trt_pkg::PT_ST;
    localparam int CFW = trt_pkg::CFG_W;
    localparam int DTW = trt_pkg::DATA_W;

    logic [CFW-1:0]       gap_reg;
    logic [CFW-1:0]       rng_reg;
    logic [CFW-1:0]       depth_reg;
    logic                 cfg_wr;
    trt_pkg::cfg_t        cfg;

    logic [S-1:0]         v_reg;
    logic [S-1:0]         v_next;
    logic [S-1:0]         en;

    trt_pkg::side_t       side_in;
    trt_pkg::side_t       side_fd;
    trt_pkg::side_t       side_dp;
    trt_pkg::front_res_t  fres;
    trt_pkg::div_res_t    dres;

    // Configuration registers. A write completes in the access phase; reads are
    // returned from the same decode.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg   <= CFW'(65536);
            rng_reg   <= CFW'(1310720);
            depth_reg <= CFW'(65536);
        end
        else if (cfg_wr)
        begin
            case (trt_pkg::cfg_idx_t'(paddr[3:2]))
                trt_pkg::REG_GAP:   gap_reg   <= pwdata[CFW-1:0];
                trt_pkg::REG_RANGE: rng_reg   <= pwdata[CFW-1:0];
                trt_pkg::REG_DEPTH: depth_reg <= pwdata[CFW-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (trt_pkg::cfg_idx_t'(paddr[3:2]))
            trt_pkg::REG_GAP:   prdata = {{(DTW-CFW){1'b0}}, gap_reg};
            trt_pkg::REG_RANGE: prdata = {{(DTW-CFW){1'b0}}, rng_reg};
            trt_pkg::REG_DEPTH: prdata = {{(DTW-CFW){1'b0}}, depth_reg};
            default:            prdata = '0;
        endcase
    end

    assign cfg.gap   = gap_reg;
    assign cfg.rng   = rng_reg;
    assign cfg.depth = depth_reg;

    // Stage k advances unless it and every stage after it are full while the
    // receiver stalls.
    genvar k;
    generate
        for (k = 0; k < S; k++)
        begin : g_en
            assign en[k] = ~(res_stall & (&v_reg[S-1:k]));
        end
    endgenerate

    assign ray_stall = ~en[0];
    assign res_valid = v_reg[S-1];
    assign v_next    = {v_reg[S-2:0], ray_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= (v_next & en) | (v_reg & ~en);
        end
    end

    assign side_in.oa[0] = origin_a_x;
    assign side_in.oa[1] = origin_a_y;
    assign side_in.oa[2] = origin_a_z;
    assign side_in.ob[0] = origin_b_x;
    assign side_in.ob[1] = origin_b_y;
    assign side_in.ob[2] = origin_b_z;
    assign side_in.da[0] = dir_a_x;
    assign side_in.da[1] = dir_a_y;
    assign side_in.da[2] = dir_a_z;
    assign side_in.db[0] = dir_b_x;
    assign side_in.db[1] = dir_b_y;
    assign side_in.db[2] = dir_b_z;
    assign side_in.par   = 1'b0;

    trt_front u_front (
        .clk      (clk),
        .en       (en[FS-1:0]),
        .side_in  (side_in),
        .side_out (side_fd),
        .res      (fres)
    );

    trt_div u_div (
        .clk      (clk),
        .en       (en[FS+DS-1:FS]),
        .side_in  (side_fd),
        .fin      (fres),
        .side_out (side_dp),
        .dout     (dres)
    );

    trt_point u_point (
        .clk      (clk),
        .en       (en[S-1:FS+DS]),
        .side_in  (side_dp),
        .din      (dres),
        .cfg      (cfg),
        .point_x  (point_x),
        .point_y  (point_y),
        .point_z  (point_z),
        .point_ok (point_valid)
    );

    // A rejected result always carries a zero point.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !point_valid |-> point_x == '0 && point_y == '0 && point_z == '0)
        else $error("rejected result with nonzero point");

    // An accepted point never lies below the minimum depth.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && point_valid |-> point_z >= $signed({1'b0, depth_reg}))
        else $error("accepted point below minimum depth");

    // A taken ray pair occupies the first stage on the next cycle.
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        ray_valid && !ray_stall |=> v_reg[0])
        else $error("ray pair lost at pipeline entry");

    // The input side stalls only when the whole pipeline is full and blocked.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        ray_stall |-> (&v_reg) && res_stall)
        else $error("input stalled while the pipeline has a free stage");

endmodule
